FILE: src/varispeed_tape_loop_overdub_defines.svh
// assertion macros for the tape looper
`ifndef VARISPEED_TAPE_LOOP_OVERDUB_DEFINES_SVH
`define VARISPEED_TAPE_LOOP_OVERDUB_DEFINES_SVH
`ifndef SYNTHESIS
`define VTL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tape looper check failed");
`define VTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tape looper check failed");
`else
`define VTL_ASSERT_NOW(label, ante, cons)
`define VTL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: src/vtl_pkg.sv
package vtl_pkg;

    localparam int TAPE_AW    = 16;
    localparam int TAPE_DEPTH = 1 << TAPE_AW;
    localparam int FRAC_W     = 16;
    localparam int POS_W      = TAPE_AW + FRAC_W;
    localparam int SMP_W      = 16;
    localparam int FRAME_W    = 2 * SMP_W;
    localparam int GAIN_W     = 16;
    localparam int SPEED_W    = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int ACC_W      = 33;
    localparam int PROD_W     = ACC_W + GAIN_W + 1;
    localparam int ROUND_SH   = 30;
    localparam int Q_W        = PROD_W - ROUND_SH;

    typedef logic [TAPE_AW-1:0]        addr_t;
    typedef logic [POS_W-1:0]          pos_t;
    typedef logic [SMP_W-1:0]          smp_t;
    typedef logic [FRAME_W-1:0]        frame_t;
    typedef logic [GAIN_W-1:0]         gain_t;
    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    localparam gain_t  GAIN_RESET  = gain_t'(16384);
    localparam speed_t SPEED_RESET = speed_t'(65536);
    localparam prod_t  ROUND_HALF  = prod_t'(1) <<< (ROUND_SH - 1);
    localparam smp_t   SMP_MAX     = 16'h7fff;
    localparam smp_t   SMP_MIN     = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOP_MODE     = 2'd0,
        CFG_OUTPUT_GAIN   = 2'd1,
        CFG_TAPE_SPEED    = 2'd2,
        CFG_RECORD_ENABLE = 2'd3
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD2  = 5'b00010,
        S_RDW  = 5'b00100,
        S_WR   = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic e1_load;
        logic acc_load;
        logic prod_load;
    } mix_ctl_t;

    // an entry holds recorded data only below the write position, or anywhere once wrapped
    function automatic logic tape_written(input addr_t addr, input addr_t wpos,
                                          input logic wrapped);
        return wrapped || (addr < wpos);
    endfunction

endpackage

FILE: src/vtl_ram.sv
module vtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: src/vtl_mix.sv
module vtl_mix (
    input  logic               clk,
    input  vtl_pkg::mix_ctl_t  ctl,
    input  vtl_pkg::frame_t    tape_word,
    input  vtl_pkg::frame_t    in_word,
    input  logic [15:0]        frac,
    input  vtl_pkg::gain_t     gain,
    output vtl_pkg::frame_t    overdub_word,
    output vtl_pkg::frame_t    out_word
);

    vtl_pkg::frame_t                     e1_reg;
    logic signed [vtl_pkg::ACC_W-1:0]    acc_reg [2];
    logic signed [vtl_pkg::ACC_W-1:0]    acc_next [2];
    vtl_pkg::prod_t                      prod_reg [2];
    vtl_pkg::prod_t                      prod_next [2];
    logic signed [16:0]                  diff [2];
    logic signed [33:0]                  interp [2];
    logic signed [33:0]                  acc_wide [2];
    logic signed [16:0]                  dub_sum [2];
    vtl_pkg::prod_t                      rnd [2];
    logic signed [vtl_pkg::Q_W-1:0]      q [2];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            // s1*(1-f) + s2*f rewritten as s1 + (s2-s1)*f
            diff[i]   = $signed({tape_word[16*i+15], tape_word[16*i +: 16]})
                      - $signed({e1_reg[16*i+15], e1_reg[16*i +: 16]});
            interp[i] = diff[i] * $signed({1'b0, frac});
            acc_wide[i] = interp[i]
                        + ($signed(e1_reg[16*i +: 16]) <<< 16)
                        + ($signed(in_word[16*i +: 16]) <<< 15);
            acc_next[i]  = acc_wide[i][vtl_pkg::ACC_W-1:0];
            prod_next[i] = acc_reg[i] * $signed({1'b0, gain});

            // round half up, floor shift, then clamp
            rnd[i] = prod_reg[i] + vtl_pkg::ROUND_HALF;
            q[i]   = rnd[i][vtl_pkg::PROD_W-1:vtl_pkg::ROUND_SH];
            if ((&q[i][vtl_pkg::Q_W-1:15]) || !(|q[i][vtl_pkg::Q_W-1:15]))
            begin
                out_word[16*i +: 16] = q[i][15:0];
            end
            else
            begin
                out_word[16*i +: 16] = q[i][vtl_pkg::Q_W-1] ? vtl_pkg::SMP_MIN
                                                            : vtl_pkg::SMP_MAX;
            end

            // floor of the halved sum is just the upper bits
            dub_sum[i] = $signed(tape_word[16*i +: 16]) + $signed(in_word[16*i +: 16]);
            overdub_word[16*i +: 16] = dub_sum[i][16:1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.e1_load)
        begin
            e1_reg <= tape_word;
        end
        for (int i = 0; i < 2; i++)
        begin
            if (ctl.acc_load)
            begin
                acc_reg[i] <= acc_next[i];
            end
            if (ctl.prod_load)
            begin
                prod_reg[i] <= prod_next[i];
            end
        end
    end

endmodule

FILE: src/varispeed_tape_loop_overdub.sv
// channel   direction  handshake             payload
// s_*       in         s_tvalid / s_tready   tdata: in_left [15:0], in_right [31:16]
// m_*       out        m_tvalid / m_tready   tdata: out_left [15:0], out_right [31:16]
// cfg_*     in         cfg_valid / cfg_ready cfg_index selects register, cfg_data value
//
// with loop mode clear, each frame runs the single-port tape memory sequence
// (read p1, read p2, read write entry, overdub write if recording, deliver);
// loop mode set: pass-through; a stalled output holds the deliver step only
// reset is immediate: no memory sweep, unrecorded entries read as zero via the
// write position and a wrap flag; cfg_ready is always high
`include "varispeed_tape_loop_overdub_defines.svh"

module varispeed_tape_loop_overdub (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // in_left [15:0], in_right [31:16]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // out_left [15:0], out_right [31:16]
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vtl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vtl_pkg::CFG_DATA_W-1:0]   cfg_data
);

    vtl_pkg::state_t   state_reg, state_next;
    logic              loop_mode_reg, loop_mode_next;
    vtl_pkg::gain_t    gain_reg, gain_next;
    vtl_pkg::speed_t   speed_reg, speed_next;
    logic              record_reg, record_next;
    vtl_pkg::pos_t     pos_reg, pos_next;
    vtl_pkg::addr_t    wpos_reg, wpos_next;
    logic              wrapped_reg, wrapped_next;
    logic              vld_reg, vld_next;
    logic              pass_reg, pass_next;
    logic              m_tvalid_reg, m_tvalid_next;
    vtl_pkg::frame_t   in_reg, in_next;
    vtl_pkg::frame_t   m_tdata_reg, m_tdata_next;

    vtl_pkg::addr_t    p1, p2, wpos_step;
    vtl_pkg::pos_t     speed_ext;
    logic              out_load;
    logic              ram_we;
    vtl_pkg::addr_t    ram_addr;
    vtl_pkg::frame_t   ram_wdata, ram_rdata;
    vtl_pkg::frame_t   tape_word, overdub_word, out_word;
    vtl_pkg::mix_ctl_t mix_ctl;

    assign p1        = pos_reg[vtl_pkg::POS_W-1:vtl_pkg::FRAC_W];
    assign p2        = p1 + vtl_pkg::addr_t'(1);
    assign wpos_step = wpos_reg + vtl_pkg::addr_t'(1);
    assign speed_ext = {{(vtl_pkg::POS_W-vtl_pkg::SPEED_W){speed_reg[vtl_pkg::SPEED_W-1]}},
                        speed_reg};
    assign tape_word = vld_reg ? ram_rdata : '0;

    assign s_tready  = (state_reg == vtl_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    vtl_ram #(
        .WIDTH (vtl_pkg::FRAME_W),
        .DEPTH (vtl_pkg::TAPE_DEPTH)
    ) u_tape (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    vtl_mix u_mix (
        .clk          (clk),
        .ctl          (mix_ctl),
        .tape_word    (tape_word),
        .in_word      (in_reg),
        .frac         (pos_reg[vtl_pkg::FRAC_W-1:0]),
        .gain         (gain_reg),
        .overdub_word (overdub_word),
        .out_word     (out_word)
    );

    always_comb
    begin
        state_next     = state_reg;
        loop_mode_next = loop_mode_reg;
        gain_next      = gain_reg;
        speed_next     = speed_reg;
        record_next    = record_reg;
        pos_next       = pos_reg;
        wpos_next      = wpos_reg;
        wrapped_next   = wrapped_reg;
        vld_next       = vld_reg;
        pass_next      = pass_reg;
        in_next        = in_reg;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = p1;
        ram_wdata      = overdub_word;
        mix_ctl        = '0;

        if (cfg_valid)
        begin
            unique case (vtl_pkg::cfg_idx_t'(cfg_index))
                vtl_pkg::CFG_LOOP_MODE:     loop_mode_next = cfg_data[0];
                vtl_pkg::CFG_OUTPUT_GAIN:   gain_next      = cfg_data[vtl_pkg::GAIN_W-1:0];
                vtl_pkg::CFG_TAPE_SPEED:    speed_next     = cfg_data;
                vtl_pkg::CFG_RECORD_ENABLE: record_next    = cfg_data[0];
                default:                    ;
            endcase
        end

        unique case (state_reg)
            vtl_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    in_next   = s_tdata;
                    pass_next = loop_mode_reg;
                    if (loop_mode_reg)
                    begin
                        state_next = vtl_pkg::S_OUT;
                    end
                    else
                    begin
                        vld_next   = vtl_pkg::tape_written(p1, wpos_reg, wrapped_reg);
                        state_next = vtl_pkg::S_RD2;
                    end
                end
            end
            vtl_pkg::S_RD2:
            begin
                ram_addr        = p2;
                mix_ctl.e1_load = 1'b1;
                vld_next        = vtl_pkg::tape_written(p2, wpos_reg, wrapped_reg);
                state_next      = vtl_pkg::S_RDW;
            end
            vtl_pkg::S_RDW:
            begin
                ram_addr         = wpos_reg;
                mix_ctl.acc_load = 1'b1;
                vld_next         = vtl_pkg::tape_written(wpos_reg, wpos_reg, wrapped_reg);
                state_next       = vtl_pkg::S_WR;
            end
            vtl_pkg::S_WR:
            begin
                // old entry arrives now, overdub goes straight back when recording
                ram_addr          = wpos_reg;
                ram_we            = record_reg;
                mix_ctl.prod_load = 1'b1;
                pos_next          = pos_reg + speed_ext;
                if (record_reg)
                begin
                    wpos_next = wpos_step;
                    if (&wpos_reg)
                    begin
                        wrapped_next = 1'b1;
                    end
                end
                state_next = vtl_pkg::S_OUT;
            end
            vtl_pkg::S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = vtl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = vtl_pkg::S_IDLE;
            end
        endcase

        m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);
        m_tdata_next  = out_load ? (pass_reg ? in_reg : out_word) : m_tdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vtl_pkg::S_IDLE;
            loop_mode_reg <= 1'b0;
            gain_reg      <= vtl_pkg::GAIN_RESET;
            speed_reg     <= vtl_pkg::SPEED_RESET;
            record_reg    <= 1'b0;
            pos_reg       <= '0;
            wpos_reg      <= '0;
            wrapped_reg   <= 1'b0;
            vld_reg       <= 1'b0;
            pass_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loop_mode_reg <= loop_mode_next;
            gain_reg      <= gain_next;
            speed_reg     <= speed_next;
            record_reg    <= record_next;
            pos_reg       <= pos_next;
            wpos_reg      <= wpos_next;
            wrapped_reg   <= wrapped_next;
            vld_reg       <= vld_next;
            pass_reg      <= pass_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg      <= in_next;
        m_tdata_reg <= m_tdata_next;
    end

    `VTL_ASSERT_NEXT(a_wrap_sticky, wrapped_reg, wrapped_reg)
    `VTL_ASSERT_NOW(a_write_at_wpos, ram_we, ram_addr == wpos_reg)
    `VTL_ASSERT_NEXT(a_wpos_advance, ram_we, wpos_reg == $past(wpos_step))
    `VTL_ASSERT_NEXT(a_loop_starts_read, s_tvalid && s_tready && !loop_mode_reg, state_reg == vtl_pkg::S_RD2)

endmodule
